FILE: rtl/core/kbdrpt_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard report package
// Shared constants, opcodes, item and report types for the key slot manager.
// ----------------------------------------------------------------------------
package kbdrpt_pkg;

	localparam int unsigned KeySlotCount = 6;
	localparam int unsigned ShownSlots   = 6;
	localparam int unsigned InDataW      = 24;
	localparam int unsigned OutDataW     = 64;
	localparam int unsigned PaddrW       = 3;
	localparam int unsigned PdataW       = 32;

	localparam logic [2:0] OP_PRESS_KEY   = 3'd0;
	localparam logic [2:0] OP_RELEASE_KEY = 3'd1;
	localparam logic [2:0] OP_MOD_SET     = 3'd2;
	localparam logic [2:0] OP_MOD_CLEAR   = 3'd3;
	localparam logic [2:0] OP_RELEASE_ALL = 3'd4;

	localparam logic REG_ROLLOVER = 1'b0;

	localparam logic [7:0] KEY_NONE       = 8'h00;
	localparam logic [7:0] ROLLOVER_RESET = 8'h01;

	// opcode in the lowest bits, then key_code, then modifier_mask
	typedef struct packed {
		logic [7:0] modifier_mask;
		logic [7:0] key_code;
		logic [2:0] opcode;
	} kbdrpt_item_t;

	typedef logic [KeySlotCount-1:0][7:0] kbdrpt_slots_t;

	typedef struct packed {
		logic [7:0]    modifier;
		kbdrpt_slots_t slots;
		logic          send;
	} kbdrpt_report_t;

	// modifier byte, shown slots, send flag from the lowest bit up
	function automatic logic [OutDataW-1:0] pack_report(input kbdrpt_report_t rpt);
		logic [OutDataW-1:0] word;
		word = '0;
		word[7:0] = rpt.modifier;
		for (int i = 0; i < ShownSlots; i++) begin
			if (i < KeySlotCount) begin
				word[8*(i+1) +: 8] = rpt.slots[i];
			end
		end
		word[8*(ShownSlots+1)] = rpt.send;
		return word;
	endfunction

endpackage

FILE: rtl/core/keyboard_report_key_slot_manager.sv
// ----------------------------------------------------------------------------
// Keyboard report key slot manager
// Boot keyboard report (modifier byte and six key slots) driven by requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: opcode, key_code and modifier_mask.
//   Opcodes press or release a key, set or clear modifier bits, or release
//   everything. Each request gives exactly one report on the m_ stream: the
//   modifier byte, the six key slots and a send_request flag.
//   The rollover code (APB register 0, address 0) is placed in slot 0 when
//   a key is pressed with every slot full; write it only while idle.
// Timing:
//   The request is held in the input register, the slot compare and
//   first-empty pick run combinationally, and the updated report lands in
//   the result register. One request per cycle is taken while the receiver
//   keeps m_tready high.
// Reset and stall:
//   Reset clears the modifier byte and every slot and sets the rollover code
//   to 1. When m_tready is low the result register holds, the input register
//   fills, and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module keyboard_report_key_slot_manager (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode[2:0], key_code[10:3], modifier_mask[18:11], zero fill
	input  logic [kbdrpt_pkg::InDataW-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// modifier_byte[7:0], slot_zero..slot_five[55:8], send_request[56], zero fill
	output logic [kbdrpt_pkg::OutDataW-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [kbdrpt_pkg::PaddrW-1:0]   paddr,
	input  logic [kbdrpt_pkg::PdataW-1:0]   pwdata,
	output logic [kbdrpt_pkg::PdataW-1:0]   prdata,
	output logic                            pready
);
	import kbdrpt_pkg::*;

	logic                s_accept;
	logic                advance;
	logic                valid_s1;
	kbdrpt_item_t        item_s1;
	logic [7:0]          modifier_q;
	kbdrpt_slots_t       slots_q;
	logic [7:0]          rollover_code;
	kbdrpt_report_t      next_rpt;
	logic                m_valid_q;
	logic [OutDataW-1:0] m_data_q;

	kbdrpt_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.rollover_code (rollover_code)
	);

	// advance the held request when the result register is free or draining
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= kbdrpt_item_t'(s_tdata[$bits(kbdrpt_item_t)-1:0]);
		end
	end

	kbdrpt_slot_update u_update (
		.item          (item_s1),
		.modifier      (modifier_q),
		.slots         (slots_q),
		.rollover_code (rollover_code),
		.next_rpt      (next_rpt)
	);

	// commit the report state only as the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modifier_q <= '0;
			slots_q    <= '0;
		end else if (advance) begin
			modifier_q <= next_rpt.modifier;
			slots_q    <= next_rpt.slots;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= pack_report(next_rpt);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

FILE: rtl/core/kbdrpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// Keyboard report configuration registers
// APB-style register file holding the rollover key code.
// ----------------------------------------------------------------------------
module kbdrpt_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kbdrpt_pkg::PaddrW-1:0] paddr,
	input  logic [kbdrpt_pkg::PdataW-1:0] pwdata,
	output logic [kbdrpt_pkg::PdataW-1:0] prdata,
	output logic                          pready,
	output logic [7:0]                    rollover_code
);
	import kbdrpt_pkg::*;

	logic       wr_en;
	logic [7:0] rollover_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rollover_q <= ROLLOVER_RESET;
		end else if (wr_en && (paddr[2] == REG_ROLLOVER)) begin
			rollover_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ROLLOVER) begin
			prdata[7:0] = rollover_q;
		end
	end

	assign rollover_code = rollover_q;

endmodule

FILE: rtl/core/kbdrpt_slot_update.sv
// ----------------------------------------------------------------------------
// Keyboard report slot update
// Applies one request to the modifier byte and key slots.
// ----------------------------------------------------------------------------
module kbdrpt_slot_update (
	input  kbdrpt_pkg::kbdrpt_item_t  item,
	input  logic [7:0]                modifier,
	input  kbdrpt_pkg::kbdrpt_slots_t slots,
	input  logic [7:0]                rollover_code,
	output kbdrpt_pkg::kbdrpt_report_t next_rpt
);
	import kbdrpt_pkg::*;

	always_comb begin
		logic present;
		logic placed;
		present = 1'b0;
		placed  = 1'b0;
		next_rpt.modifier = modifier;
		next_rpt.slots    = slots;
		next_rpt.send     = 1'b0;
		// an empty slot matches key code zero
		for (int i = 0; i < KeySlotCount; i++) begin
			if (slots[i] == item.key_code) begin
				present = 1'b1;
			end
		end
		case (item.opcode)
			OP_PRESS_KEY: begin
				if (!present) begin
					next_rpt.send = 1'b1;
					for (int i = 0; i < KeySlotCount; i++) begin
						if (!placed && (slots[i] == KEY_NONE)) begin
							next_rpt.slots[i] = item.key_code;
							placed = 1'b1;
						end
					end
					if (!placed) begin
						next_rpt.slots    = '0;
						next_rpt.slots[0] = rollover_code;
					end
				end
			end
			OP_RELEASE_KEY: begin
				for (int i = 0; i < KeySlotCount; i++) begin
					if (!placed && (slots[i] == item.key_code)) begin
						next_rpt.slots[i] = KEY_NONE;
						placed = 1'b1;
					end
				end
				next_rpt.send = placed;
			end
			OP_MOD_SET: begin
				next_rpt.modifier = modifier | item.modifier_mask;
				next_rpt.send     = 1'b1;
			end
			OP_MOD_CLEAR: begin
				next_rpt.modifier = modifier & ~item.modifier_mask;
				next_rpt.send     = 1'b1;
			end
			OP_RELEASE_ALL: begin
				next_rpt.modifier = '0;
				next_rpt.slots    = '0;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Key slot manager testbench
// Drives press, release, modifier and release-all requests into the keyboard
// report block over the s_ stream, with random gaps on both sides. A tracker
// keeps its own copy of the modifier byte and the six key slots. It predicts
// each report and checks it field by field against the m_ stream. Phases
// change the rollover code over APB while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	import kbdrpt_pkg::*;

	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          PHASE_ITEMS   = 310;
	localparam int          MAX_PRINTED   = 40;
	localparam logic [2:0]  OP_NOP_FIRST  = 3'd5;
	localparam logic [2:0]  OP_NOP_MID    = 3'd6;
	localparam logic [2:0]  OP_NOP_LAST   = 3'd7;
	localparam logic [PaddrW-1:0] ROLLOVER_ADDR = {REG_ROLLOVER, 2'b00};

	// ------------------------------------------------------------------
	// Report tracker: own copy of the report state, expected reports in
	// request order, mismatch count and a few coverage counters.
	// ------------------------------------------------------------------
	class report_tracker;
		logic [7:0]     rollover_code;
		logic [7:0]     modifier;
		logic [7:0]     slots [KeySlotCount];
		kbdrpt_report_t pending_reports [$];
		int             errors;
		int             requests;
		int             checked;
		int             rollovers;
		int             ignored_presses;
		int             sends;

		function new();
			int i;
			rollover_code = ROLLOVER_RESET;
			modifier = '0;
			for (i = 0; i < KeySlotCount; i++) slots[i] = KEY_NONE;
			errors = 0;
			requests = 0;
			checked = 0;
			rollovers = 0;
			ignored_presses = 0;
			sends = 0;
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction

		function void set_rollover(logic [7:0] value);
			rollover_code = value;
		endfunction

		function void report_mismatch(string field, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= MAX_PRINTED) begin
				$display("mismatch on %s: got %0h, want %0h (report %0d)",
					field, got, want, checked);
			end
		endfunction

		// apply one accepted request and queue the report it must produce
		function void note_request(logic [InDataW-1:0] data);
			kbdrpt_item_t   req;
			kbdrpt_report_t rpt;
			logic           send;
			logic           hit;
			int             i;
			req = data[$bits(kbdrpt_item_t)-1:0];
			send = 1'b0;
			hit = 1'b0;
			requests++;
			case (req.opcode)
				OP_PRESS_KEY: begin
					// a code already held (code 0 on any empty slot) is ignored
					for (i = 0; i < KeySlotCount; i++) begin
						if (slots[i] == req.key_code) hit = 1'b1;
					end
					if (hit) begin
						ignored_presses++;
					end else begin
						for (i = 0; i < KeySlotCount; i++) begin
							if (!hit && slots[i] == KEY_NONE) begin
								slots[i] = req.key_code;
								hit = 1'b1;
							end
						end
						// every slot full: wipe and flag rollover in slot 0
						if (!hit) begin
							rollovers++;
							for (i = 0; i < KeySlotCount; i++) slots[i] = KEY_NONE;
							slots[0] = rollover_code;
						end
						send = 1'b1;
					end
				end
				OP_RELEASE_KEY: begin
					for (i = 0; i < KeySlotCount; i++) begin
						if (!send && slots[i] == req.key_code) begin
							slots[i] = KEY_NONE;
							send = 1'b1;
						end
					end
				end
				OP_MOD_SET: begin
					modifier = modifier | req.modifier_mask;
					send = 1'b1;
				end
				OP_MOD_CLEAR: begin
					modifier = modifier & ~req.modifier_mask;
					send = 1'b1;
				end
				OP_RELEASE_ALL: begin
					modifier = '0;
					for (i = 0; i < KeySlotCount; i++) slots[i] = KEY_NONE;
				end
				default: begin
				end
			endcase
			if (send) sends++;
			rpt.modifier = modifier;
			for (i = 0; i < KeySlotCount; i++) rpt.slots[i] = slots[i];
			rpt.send = send;
			pending_reports.push_back(rpt);
		endfunction

		function void check_report(logic [OutDataW-1:0] word);
			kbdrpt_report_t want;
			int             i;
			checked++;
			if (pending_reports.size() == 0) begin
				report_mismatch("report with no request waiting", 64'(word), '0);
				return;
			end
			want = pending_reports.pop_front();
			if (word[7:0] !== want.modifier) begin
				report_mismatch("modifier_byte", 64'(word[7:0]), 64'(want.modifier));
			end
			for (i = 0; i < ShownSlots; i++) begin
				if (word[8*(i+1) +: 8] !== want.slots[i]) begin
					report_mismatch($sformatf("slot %0d", i), 64'(word[8*(i+1) +: 8]),
						64'(want.slots[i]));
				end
			end
			if (word[8*(ShownSlots+1)] !== want.send) begin
				report_mismatch("send_request", 64'(word[8*(ShownSlots+1)]),
					64'(want.send));
			end
			if (word[OutDataW-1:8*(ShownSlots+1)+1] !== '0) begin
				report_mismatch("zero fill", 64'(word[OutDataW-1:8*(ShownSlots+1)+1]), '0);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// opcode[2:0], key_code[10:3], modifier_mask[18:11], zero fill
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	// modifier_byte[7:0], slot_zero..slot_five[55:8], send_request[56], zero fill
	logic [OutDataW-1:0] m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PaddrW-1:0]   paddr;
	logic [PdataW-1:0]   pwdata;
	logic [PdataW-1:0]   prdata;
	logic                pready;

	report_tracker tracker = new();
	bit            idling = 1'b1;
	int            cycle_count = 0;
	int            settings_used = 1;

	keyboard_report_key_slot_manager u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sample both streams at the rising edge; note the request first so a
	// same-edge report always finds its expectation queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) tracker.note_request(s_tdata);
			if (m_tvalid && m_tready) tracker.check_report(m_tdata);
		end
	end

	// Receiver: stall with a probability of about 22 percent unless idling is off.
	always @(negedge clk) begin
		m_tready <= !idling || ($urandom_range(99) >= 22);
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding",
				cycle_count, tracker.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one request, with random gaps ahead of it. Returns on the
	// falling edge after acceptance with tvalid still high.
	task automatic drive_request(logic [2:0] op, logic [7:0] key, logic [7:0] mask);
		kbdrpt_item_t req;
		req.opcode = op;
		req.key_code = key;
		req.modifier_mask = mask;
		while (idling && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= InDataW'(req);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop tvalid and wait for every outstanding report.
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the rollover code, then read it back.
	task automatic write_rollover(logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ROLLOVER_ADDR;
		pwdata <= PdataW'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_rollover(value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== value) begin
			tracker.report_mismatch("rollover_code read back", 64'(prdata), 64'(value));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	// Key codes: mostly a small pool so slots fill and repeat, some zero,
	// some anything; releases often aim at a code actually held.
	function automatic logic [7:0] pick_key(bit aim_at_held);
		int r;
		r = $urandom_range(99);
		if (aim_at_held && r < 50) return tracker.slots[$urandom_range(KeySlotCount-1)];
		if (r < 75) return 8'($urandom_range(9, 1));
		if (r < 83) return KEY_NONE;
		return 8'($urandom_range(255));
	endfunction

	// Mostly well-formed key traffic; a little release-all, no-op and noise.
	task automatic random_requests(int count);
		int         done;
		int         r;
		logic [2:0] op;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			if (r < 45) begin
				drive_request(OP_PRESS_KEY, pick_key(1'b0), 8'($urandom_range(255)));
			end else if (r < 70) begin
				drive_request(OP_RELEASE_KEY, pick_key(1'b1), 8'($urandom_range(255)));
			end else if (r < 80) begin
				drive_request(OP_MOD_SET, 8'($urandom_range(255)), 8'($urandom_range(255)));
			end else if (r < 88) begin
				drive_request(OP_MOD_CLEAR, 8'($urandom_range(255)),
					8'($urandom_range(255)));
			end else if (r < 92) begin
				drive_request(OP_RELEASE_ALL, 8'($urandom_range(255)),
					8'($urandom_range(255)));
			end else begin
				op = 3'($urandom_range(7));
				drive_request(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
			end
			// ignored opcodes do not count toward the phase
			if (!(s_tdata[2:0] >= OP_NOP_FIRST && s_tdata[2:0] <= OP_NOP_LAST)) done++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty-slot corner cases, fill, rollover, modifiers, no-ops.
		drive_request(OP_PRESS_KEY, KEY_NONE, 8'h00);   // code 0 matches an empty slot
		drive_request(OP_RELEASE_KEY, KEY_NONE, 8'hFF); // clears an empty slot, sends
		drive_request(OP_PRESS_KEY, 8'hFF, 8'h00);
		drive_request(OP_PRESS_KEY, 8'h04, 8'h00);
		drive_request(OP_PRESS_KEY, 8'h04, 8'h00);      // already held
		drive_request(OP_RELEASE_KEY, 8'h55, 8'h00);    // not held
		drive_request(OP_PRESS_KEY, 8'h05, 8'h00);
		drive_request(OP_PRESS_KEY, 8'h06, 8'h00);
		drive_request(OP_PRESS_KEY, 8'h07, 8'h00);
		drive_request(OP_PRESS_KEY, 8'h08, 8'h00);      // all six slots full
		drive_request(OP_PRESS_KEY, KEY_NONE, 8'h00);   // zero on a full report rolls over
		drive_request(OP_RELEASE_KEY, ROLLOVER_RESET, 8'h00);
		drive_request(OP_PRESS_KEY, 8'h80, 8'h00);
		drive_request(OP_MOD_SET, 8'h00, 8'hFF);
		drive_request(OP_MOD_CLEAR, 8'hFF, 8'h0F);
		drive_request(OP_MOD_SET, 8'h00, 8'h00);
		drive_request(OP_MOD_CLEAR, 8'h00, 8'hFF);
		drive_request(OP_MOD_SET, 8'h00, 8'hA5);
		drive_request(OP_RELEASE_KEY, 8'h80, 8'h00);
		drive_request(OP_RELEASE_ALL, 8'hFF, 8'hFF);    // clears everything, no send
		drive_request(OP_NOP_FIRST, 8'hFF, 8'hFF);
		drive_request(OP_NOP_MID, 8'h00, 8'h00);
		drive_request(OP_NOP_LAST, 8'h3C, 8'hC3);
		drain_reports();

		// Random phases across rollover codes, one with no idling at all.
		random_requests(PHASE_ITEMS);
		drain_reports();
		write_rollover(8'h00);
		random_requests(PHASE_ITEMS);
		drain_reports();
		write_rollover(8'hFF);
		idling = 1'b0;
		random_requests(PHASE_ITEMS);
		drain_reports();
		idling = 1'b1;
		write_rollover(8'($urandom_range(254, 1)));
		random_requests(PHASE_ITEMS);
		drain_reports();
		repeat (8) @(negedge clk);

		$display("ran %0d requests under %0d rollover codes; %0d reports checked",
			tracker.requests, settings_used, tracker.checked);
		$display("saw %0d rollovers, %0d ignored presses, %0d send requests, %0d mismatches",
			tracker.rollovers, tracker.ignored_presses, tracker.sends, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
